// ===== rtl/tpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared types and constants for the tour permutation edit engine.
// ----------------------------------------------------------------------------
package tpe_pkg;

  localparam int IDX_W          = 9;
  localparam int CITY_W         = 8;
  localparam int OP_W           = 3;
  localparam int TPE_MAX_CITIES = 256;
  localparam logic [IDX_W-1:0] CNT_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_SWAP    = 3'd2,
    OP_REVERSE = 3'd3,
    OP_ROTATE  = 3'd4,
    OP_MOVE    = 3'd5
  } tpe_op_t;

  // which pair of item indices bounds the next flip, as [lo,hi)
  typedef enum logic [2:0] {
    RNG_AB = 3'd0,
    RNG_BC = 3'd1,
    RNG_AC = 3'd2,
    RNG_CA = 3'd3,
    RNG_CB = 3'd4
  } tpe_rng_t;

  typedef struct packed {
    logic     load_item;
    logic     range_ld;
    tpe_rng_t range_sel;
    logic     wr_city;
    logic     wr_lo;
    logic     wr_hi;
    logic     res_ld;
  } tpe_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            rev;
    logic            ok;
    logic            c_ge_b;
    logic            pair_ok;
  } tpe_stat_t;

endpackage

// ===== rtl/tpe_if.sv =====
// ----------------------------------------------------------------------------
// tpe channel interfaces
// Valid/ready channels for items, results and the city count register.
// ----------------------------------------------------------------------------
interface tpe_in_if import tpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  index_a;
  logic [IDX_W-1:0]  index_b;
  logic [IDX_W-1:0]  index_c;
  logic              reverse_segment;
  logic [CITY_W-1:0] city_value;

  modport source (output valid, operation, index_a, index_b, index_c,
                  reverse_segment, city_value, input ready);
  modport sink   (input valid, operation, index_a, index_b, index_c,
                  reverse_segment, city_value, output ready);
endinterface

interface tpe_out_if import tpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CITY_W-1:0] read_value;
  logic              status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

interface tpe_cfg_if import tpe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] num_cities;

  modport source (output valid, num_cities, input ready);
  modport sink   (input valid, num_cities, output ready);
endinterface

// ===== rtl/tour_permutation_edit_engine.sv =====
// ----------------------------------------------------------------------------
// tour_permutation_edit_engine
// Tour store with write, read, swap, reverse, rotate and segment move edits.
//
//   channel  dir  handshake          word
//   in_ch    in   valid / ready      operation, index_a/b/c, reverse_segment,
//                                    city_value
//   out_ch   out  valid / ready      read_value, status
//   cfg_ch   in   valid / ready      num_cities
//
// One item at a time.
// Reverse, rotate and move are runs of range flips (1 to 4); each exchanged
// pair is written lo then hi through the single ram write port.
// No clearing pass after reset; both readies are low while reset is held and
// cfg ready is high otherwise.
// A new item is taken while a result waits; a stalled result holds the next
// item in its last cycle.
// ----------------------------------------------------------------------------
module tour_permutation_edit_engine import tpe_pkg::*; #(
  parameter int MAX_CITIES = TPE_MAX_CITIES
) (
  input logic      clk,
  input logic      rst_n,
  tpe_in_if.sink   in_ch,
  tpe_out_if.source out_ch,
  tpe_cfg_if.sink  cfg_ch
);

  tpe_cmd_t  cmd;
  tpe_stat_t stat;

  assign cfg_ch.ready = rst_n;

  tpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpe_dp #(
    .MAX_CITIES (MAX_CITIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_ch.valid),
    .cfg_data        (cfg_ch.num_cities),
    .operation       (in_ch.operation),
    .index_a         (in_ch.index_a),
    .index_b         (in_ch.index_b),
    .index_c         (in_ch.index_c),
    .reverse_segment (in_ch.reverse_segment),
    .city_value      (in_ch.city_value),
    .cmd             (cmd),
    .stat            (stat),
    .read_value      (out_ch.read_value),
    .status          (out_ch.status)
  );

endmodule

// ===== rtl/tpe_ram.sv =====
// ----------------------------------------------------------------------------
// tpe_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ===== rtl/tpe_dp.sv =====
// ----------------------------------------------------------------------------
// tpe_dp
// Datapath: item registers, index checks, flip pointers, tour RAM, result.
// ----------------------------------------------------------------------------
module tpe_dp import tpe_pkg::*; #(
  parameter int MAX_CITIES = TPE_MAX_CITIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_data,
  input  logic [OP_W-1:0]   operation,
  input  logic [IDX_W-1:0]  index_a,
  input  logic [IDX_W-1:0]  index_b,
  input  logic [IDX_W-1:0]  index_c,
  input  logic              reverse_segment,
  input  logic [CITY_W-1:0] city_value,
  input  tpe_cmd_t          cmd,
  output tpe_stat_t         stat,
  output logic [CITY_W-1:0] read_value,
  output logic              status
);

  localparam int AW = $clog2(MAX_CITIES);
  localparam int CW = $clog2(MAX_CITIES + 1);
  localparam int NW = (CW > IDX_W) ? CW : IDX_W;

  logic [IDX_W-1:0]  num_cities_r;
  logic [OP_W-1:0]   op_r;
  logic [IDX_W-1:0]  a_r, b_r, c_r;
  logic              rev_r;
  logic [CITY_W-1:0] city_r;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [CITY_W-1:0] hold_r;
  logic [CITY_W-1:0] read_value_r;
  logic              status_r;

  logic [NW-1:0]     n, cnt_ext, a_w, b_w, c_w;
  logic [IDX_W-1:0]  hi_m1;
  logic              ok;
  logic              ram_we;
  logic [AW-1:0]     waddr;
  logic [CITY_W-1:0] wdata;
  logic [CITY_W-1:0] rd0, rd1;

  // active count saturates at the store depth
  assign cnt_ext = NW'(num_cities_r);
  assign n       = (cnt_ext > NW'(MAX_CITIES)) ? NW'(MAX_CITIES) : cnt_ext;
  assign a_w     = NW'(a_r);
  assign b_w     = NW'(b_r);
  assign c_w     = NW'(c_r);

  always_comb begin
    case (op_r)
      OP_WRITE, OP_READ: ok = (a_w < n);
      OP_SWAP:           ok = (a_w < n) && (b_w < n);
      OP_REVERSE:        ok = (a_w <= b_w) && (b_w <= n);
      OP_ROTATE:         ok = (a_w <= b_w) && (b_w <= c_w) && (c_w <= n);
      OP_MOVE:           ok = (a_w <= b_w) && (b_w <= n) && (c_w <= n) &&
                              ((c_w <= a_w) || (c_w >= b_w));
      default:           ok = 1'b0;
    endcase
  end

  assign hi_m1 = hi_r - IDX_W'(1);

  always_comb begin
    stat.op      = op_r;
    stat.rev     = rev_r;
    stat.ok      = ok;
    stat.c_ge_b  = (c_r >= b_r);
    stat.pair_ok = ({1'b0, lo_r} + (IDX_W+1)'(1)) < {1'b0, hi_r};
  end

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.load_item) begin
      // read and swap address a and b directly
      lo_nxt = index_a;
      hi_nxt = index_b + IDX_W'(1);
    end else if (cmd.range_ld) begin
      case (cmd.range_sel)
        RNG_AB:  begin lo_nxt = a_r; hi_nxt = b_r; end
        RNG_BC:  begin lo_nxt = b_r; hi_nxt = c_r; end
        RNG_AC:  begin lo_nxt = a_r; hi_nxt = c_r; end
        RNG_CA:  begin lo_nxt = c_r; hi_nxt = a_r; end
        RNG_CB:  begin lo_nxt = c_r; hi_nxt = b_r; end
        default: begin lo_nxt = lo_r; hi_nxt = hi_r; end
      endcase
    end else if (cmd.wr_hi) begin
      lo_nxt = lo_r + IDX_W'(1);
      hi_nxt = hi_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cities_r <= CNT_RESET;
    end else if (cfg_we) begin
      num_cities_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= operation;
      a_r    <= index_a;
      b_r    <= index_b;
      c_r    <= index_c;
      rev_r  <= reverse_segment;
      city_r <= city_value;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.wr_lo) begin
      hold_r <= rd0;
    end
    if (cmd.res_ld) begin
      read_value_r <= (op_r == OP_READ && ok) ? rd0 : '0;
      status_r     <= !ok;
    end
  end

  assign ram_we = cmd.wr_city | cmd.wr_lo | cmd.wr_hi;
  assign waddr  = cmd.wr_hi ? AW'(hi_m1) : AW'(lo_r);
  assign wdata  = cmd.wr_city ? city_r : (cmd.wr_lo ? rd1 : hold_r);

  tpe_ram #(
    .WIDTH (CITY_W),
    .DEPTH (MAX_CITIES)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (AW'(lo_r)),
    .raddr1 (AW'(hi_m1)),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  assign read_value = read_value_r;
  assign status     = status_r;

endmodule

// ===== rtl/tpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpe_ctrl
// Controller: sequences checks, flip passes and pair exchanges per item.
// ----------------------------------------------------------------------------
module tpe_ctrl import tpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tpe_stat_t stat,
  output tpe_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RANGE,
    S_TEST,
    S_W1,
    S_W2,
    S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [1:0] pos;
  logic       back;
  logic       last;
  tpe_rng_t   sel;

  // rotate(x,y,z) is flip [x,y), flip [y,z), flip [x,z); a reversed move
  // adds one leading flip of the segment
  always_comb begin
    pos  = step_r + (((stat.op == OP_ROTATE) ||
                      (stat.op == OP_MOVE && !stat.rev)) ? 2'd1 : 2'd0);
    back = (stat.op == OP_MOVE) && !stat.c_ge_b;
    last = (stat.op == OP_REVERSE) || (pos == 2'd3);
    case (pos)
      2'd0:    sel = RNG_AB;
      2'd1:    sel = back ? RNG_CA : RNG_AB;
      2'd2:    sel = back ? RNG_AB : RNG_BC;
      2'd3:    sel = back ? RNG_CB : RNG_AC;
      default: sel = RNG_AB;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.range_sel = sel;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          step_nxt      = 2'd0;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.ok) begin
          state_nxt = S_FIN;
        end else begin
          case (stat.op)
            OP_WRITE: begin
              cmd.wr_city = 1'b1;
              state_nxt   = S_FIN;
            end
            OP_READ:  state_nxt = S_FIN;
            OP_SWAP:  state_nxt = S_W1;
            default:  state_nxt = S_RANGE;
          endcase
        end
      end
      S_RANGE: begin
        cmd.range_ld = 1'b1;
        state_nxt    = S_TEST;
      end
      S_TEST: begin
        if (stat.pair_ok) begin
          state_nxt = S_W1;
        end else if (last) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = S_RANGE;
        end
      end
      S_W1: begin
        cmd.wr_lo = 1'b1;
        state_nxt = S_W2;
      end
      S_W2: begin
        cmd.wr_hi = 1'b1;
        state_nxt = (stat.op == OP_SWAP) ? S_FIN : S_TEST;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // no word is taken while reset is held
  assign in_ready  = (state_r == S_IDLE) && rst_n;
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_city, cmd.wr_lo, cmd.wr_hi}))
    else $error("more than one ram write command");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_W1 |=> state_r == S_W2)
    else $error("pair exchange split");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CHECK)
    else $error("accepted word not checked");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");
`endif

endmodule
